### hdl/tel_pkg.sv
// Shared constants, codes and types for the tour edge edit log engine.
// No dependencies; used by tel_ram users and the top level.
package tel_pkg;

    localparam int MaxCities = 256;
    localparam int LogDepth  = 256;
    localparam int DistWidth = 32;
    localparam int CityW     = 8;
    localparam int CountW    = 9;
    localparam int DeltaW    = 41;
    localparam int SumW      = 42;
    localparam int DistAddrW = 2 * CityW;
    localparam int LogEntryW = 3 * CityW;

    typedef enum logic [2:0] {
        REQ_INIT    = 3'd0,
        REQ_LOAD    = 3'd1,
        REQ_CHANGE  = 3'd2,
        REQ_SWAP    = 3'd3,
        REQ_QUERY   = 3'd4,
        REQ_COMMIT  = 3'd5,
        REQ_DISCARD = 3'd6,
        REQ_NONE    = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_UNUSED  = 2'd3
    } status_t;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_EXEC     = 10'b0000000010,
        S_INIT     = 10'b0000000100,
        S_QRES     = 10'b0000001000,
        S_CHG_RD   = 10'b0000010000,
        S_CHG_WR   = 10'b0000100000,
        S_UNDO_LOG = 10'b0001000000,
        S_UNDO_NBR = 10'b0010000000,
        S_UNDO_WR  = 10'b0100000000,
        S_UNDO_ADD = 10'b1000000000
    } state_t;

    typedef struct packed {
        logic [CityW-1:0] nw;
        logic [CityW-1:0] old;
        logic [CityW-1:0] v1;
    } log_entry_t;

endpackage

### hdl/tel_ram.sv
// Generic simple dual-port synchronous RAM, one write and one read port.
// Read data is registered. No dependencies.
module tel_ram #(
    parameter int DATA_W = 16,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);
    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end
endmodule

### hdl/tour_edge_edit_log_engine.sv
// Request sequencer for the tour edge edit log engine; instantiates tel_ram
// three times (neighbor table, distance store, edit log). Uses tel_pkg.
//
// One request is worked at a time and every request gives exactly one result
// beat. Commit and discard undo each log entry in turn, newest first; each
// undone entry is a chain of dependent accesses on the single-read-port
// memories (log read, neighbor and old distance read, neighbor write and new
// distance read, accumulate). A new request beat is taken while the previous
// result still waits in the output register.
module tour_edge_edit_log_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,      // num_cities
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,       // vertex_a, vertex_b, vertex_c, vertex_d, distance_value
    input  logic [2:0]  s_tuser,       // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata        // status, neighbor_first, neighbor_second,
                                       // commit_delta, log_entries, zero fill
);
    import tel_pkg::*;

    state_t state_reg, state_next;
    logic [CountW-1:0] num_cities_reg;
    logic [CountW-1:0] count_reg, count_next;
    logic [CountW-1:0] k_reg, k_next;
    logic [CityW-1:0]  idx_reg, idx_next;
    logic [1:0]        sel_reg, sel_next;
    logic [1:0]        last_reg, last_next;
    logic [SumW-1:0]   sum_reg, sum_next;
    log_entry_t        ent_reg, ent_next;
    logic              pend_reg, pend_next;
    status_t           res_status_reg, res_status_next;
    logic [CityW-1:0]  res_n0_reg, res_n0_next, res_n1_reg, res_n1_next;
    logic              res_commit_reg, res_commit_next;

    req_t             req_reg;
    logic [CityW-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [DistWidth-1:0] dval_reg;

    logic        mvalid_reg;
    logic [71:0] mdata_reg;

    logic                  nbr_we, dist_we, log_we;
    logic [CityW-1:0]      nbr_waddr, nbr_raddr;
    logic [2*CityW-1:0]    nbr_wdata, nbr_rdata;
    logic [DistAddrW-1:0]  dist_raddr;
    logic [DistWidth-1:0]  dist_rdata;
    logic [CityW-1:0]      log_waddr, log_raddr;
    log_entry_t            log_wdata, log_rdata;

    logic [CityW-1:0] cv1, cold, cnew;
    logic [CityW-1:0] last_city;
    logic [SumW-1:0]  dist_ext;
    logic [SumW-1:0]  half;
    logic             accept, out_free;

    tel_ram #(.DATA_W(2*CityW), .ADDR_W(CityW)) u_nbr (
        .aclk(aclk), .we(nbr_we), .waddr(nbr_waddr), .wdata(nbr_wdata),
        .raddr(nbr_raddr), .rdata(nbr_rdata)
    );
    tel_ram #(.DATA_W(DistWidth), .ADDR_W(DistAddrW)) u_dist (
        .aclk(aclk), .we(dist_we), .waddr({a_reg, b_reg}), .wdata(dval_reg),
        .raddr(dist_raddr), .rdata(dist_rdata)
    );
    tel_ram #(.DATA_W(LogEntryW), .ADDR_W(CityW)) u_log (
        .aclk(aclk), .we(log_we), .waddr(log_waddr), .wdata(log_wdata),
        .raddr(log_raddr), .rdata(log_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE) && !pend_reg;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = mdata_reg;
    assign out_free  = !mvalid_reg || m_tready;

    assign last_city = CityW'(num_cities_reg - CountW'(1));
    assign dist_ext  = SumW'(signed'(dist_rdata));
    // Halve toward zero: bias negative sums by one before the shift.
    assign half = SumW'($signed(sum_reg + SumW'(sum_reg[SumW-1])) >>> 1);

    // Swap edges (a,b),(c,d) as four changes; a plain change uses the first.
    always_comb begin
        case (sel_reg)
            2'd0: begin cv1 = a_reg; cold = b_reg; cnew = c_reg; end
            2'd1: begin cv1 = b_reg; cold = a_reg; cnew = d_reg; end
            2'd2: begin cv1 = d_reg; cold = c_reg; cnew = b_reg; end
            default: begin cv1 = c_reg; cold = d_reg; cnew = a_reg; end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        idx_next        = idx_reg;
        sel_next        = sel_reg;
        last_next       = last_reg;
        sum_next        = sum_reg;
        ent_next        = ent_reg;
        pend_next       = pend_reg;
        res_status_next = res_status_reg;
        res_n0_next     = res_n0_reg;
        res_n1_next     = res_n1_reg;
        res_commit_next = res_commit_reg;
        nbr_we          = 1'b0;
        nbr_waddr       = cv1;
        nbr_wdata       = nbr_rdata;
        nbr_raddr       = cv1;
        dist_we         = 1'b0;
        dist_raddr      = {ent_reg.v1, ent_reg.old};
        log_we          = 1'b0;
        log_waddr       = count_reg[CityW-1:0];
        log_wdata       = '{nw: cnew, old: cold, v1: cv1};
        log_raddr       = k_reg[CityW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next      = S_EXEC;
                    res_status_next = ST_OK;
                    res_n0_next     = '0;
                    res_n1_next     = '0;
                    res_commit_next = 1'b0;
                    sum_next        = '0;
                    sel_next        = 2'd0;
                end
            end
            S_EXEC: begin
                state_next = S_IDLE;
                pend_next  = 1'b1;
                case (req_reg)
                    REQ_INIT: begin
                        if (num_cities_reg < CountW'(3) ||
                            num_cities_reg > CountW'(MaxCities)) begin
                            res_status_next = ST_RANGE;
                        end else begin
                            pend_next  = 1'b0;
                            idx_next   = '0;
                            state_next = S_INIT;
                        end
                    end
                    REQ_LOAD: begin
                        dist_we = 1'b1;
                    end
                    REQ_CHANGE, REQ_SWAP: begin
                        last_next = (req_reg == REQ_SWAP) ? 2'd3 : 2'd0;
                        if ((req_reg == REQ_SWAP &&
                             count_reg > CountW'(LogDepth - 4)) ||
                            count_reg >= CountW'(LogDepth)) begin
                            res_status_next = ST_FULL;
                        end else begin
                            pend_next  = 1'b0;
                            state_next = S_CHG_RD;
                        end
                    end
                    REQ_QUERY: begin
                        nbr_raddr  = a_reg;
                        pend_next  = 1'b0;
                        state_next = S_QRES;
                    end
                    REQ_COMMIT, REQ_DISCARD: begin
                        res_commit_next = (req_reg == REQ_COMMIT);
                        k_next          = count_reg;
                        if (count_reg != '0) begin
                            pend_next  = 1'b0;
                            state_next = S_UNDO_LOG;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_INIT: begin
                nbr_we    = 1'b1;
                nbr_waddr = idx_reg;
                if (idx_reg == '0) begin
                    nbr_wdata = {CityW'(1), last_city};
                end else if (idx_reg == last_city) begin
                    nbr_wdata = {CityW'(0), CityW'(last_city - CityW'(1))};
                end else begin
                    nbr_wdata = {CityW'(idx_reg + CityW'(1)),
                                 CityW'(idx_reg - CityW'(1))};
                end
                idx_next = CityW'(idx_reg + CityW'(1));
                if (idx_reg == last_city) begin
                    count_next = '0;
                    pend_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_QRES: begin
                res_n0_next = nbr_rdata[CityW-1:0];
                res_n1_next = nbr_rdata[2*CityW-1:CityW];
                pend_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_CHG_RD: begin
                state_next = S_CHG_WR;
            end
            S_CHG_WR: begin
                nbr_we = 1'b1;
                if (nbr_rdata[CityW-1:0] == cold) begin
                    nbr_wdata = {nbr_rdata[2*CityW-1:CityW], cnew};
                end else begin
                    nbr_wdata = {cnew, nbr_rdata[CityW-1:0]};
                end
                log_we     = 1'b1;
                count_next = CountW'(count_reg + CountW'(1));
                sel_next   = 2'(sel_reg + 2'd1);
                if (sel_reg == last_reg) begin
                    pend_next  = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    state_next = S_CHG_RD;
                end
            end
            S_UNDO_LOG: begin
                k_next     = CountW'(k_reg - CountW'(1));
                log_raddr  = k_next[CityW-1:0];
                state_next = S_UNDO_NBR;
            end
            S_UNDO_NBR: begin
                ent_next   = log_rdata;
                nbr_raddr  = log_rdata.v1;
                dist_raddr = {log_rdata.v1, log_rdata.old};
                state_next = S_UNDO_WR;
            end
            S_UNDO_WR: begin
                nbr_we    = 1'b1;
                nbr_waddr = ent_reg.v1;
                if (nbr_rdata[CityW-1:0] == ent_reg.nw) begin
                    nbr_wdata = {nbr_rdata[2*CityW-1:CityW], ent_reg.old};
                end else begin
                    nbr_wdata = {ent_reg.old, nbr_rdata[CityW-1:0]};
                end
                sum_next   = SumW'(sum_reg - dist_ext);
                dist_raddr = {ent_reg.v1, ent_reg.nw};
                state_next = S_UNDO_ADD;
            end
            S_UNDO_ADD: begin
                sum_next = SumW'(sum_reg + dist_ext);
                if (k_reg == '0) begin
                    count_next = '0;
                    pend_next  = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    state_next = S_UNDO_LOG;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // A finished result leaves for the output register once it is free;
        // until then the sequencer holds in idle without taking a new beat.
        if (pend_reg && !out_free) begin
            state_next = state_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            num_cities_reg <= CountW'(MaxCities);
            count_reg      <= '0;
            pend_reg       <= 1'b0;
            mvalid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                num_cities_reg <= cfg_data;
            end
            if (pend_reg && out_free) begin
                state_reg  <= state_next;
                count_reg  <= count_next;
                pend_reg   <= 1'b0;
                mvalid_reg <= 1'b1;
            end else begin
                if (!pend_reg) begin
                    state_reg <= state_next;
                    count_reg <= count_next;
                    pend_reg  <= pend_next;
                end
                if (m_tready) begin
                    mvalid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!pend_reg) begin
            k_reg          <= k_next;
            idx_reg        <= idx_next;
            sel_reg        <= sel_next;
            last_reg       <= last_next;
            sum_reg        <= sum_next;
            ent_reg        <= ent_next;
            res_status_reg <= res_status_next;
            res_n0_reg     <= res_n0_next;
            res_n1_reg     <= res_n1_next;
            res_commit_reg <= res_commit_next;
        end
        if (accept) begin
            req_reg  <= req_t'(s_tuser);
            a_reg    <= s_tdata[7:0];
            b_reg    <= s_tdata[15:8];
            c_reg    <= s_tdata[23:16];
            d_reg    <= s_tdata[31:24];
            dval_reg <= s_tdata[63:32];
        end
        if (pend_reg && out_free) begin
            mdata_reg <= {4'd0, count_reg,
                          res_commit_reg ? half[DeltaW-1:0] : DeltaW'(0),
                          res_n1_reg, res_n0_reg, res_status_reg};
        end
    end
endmodule

### tb/tour_edge_edit_log_engine_tb.sv
// Self-checking testbench for the tour edge edit log engine: directed table, then random
// phases, bursty input, stalling output; checked against typed answers or a predictor.
// Depends on tel_pkg and tour_edge_edit_log_engine only.
module tour_edge_edit_log_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tel_pkg::*;

    typedef struct packed {
        status_t         status;
        logic [7:0]      first_nbr;
        logic [7:0]      second_nbr;
        logic [40:0]     delta;
        logic [8:0]      entries;
    } answer_t;

    typedef struct {
        logic          is_cfg;
        logic [8:0]    cfg_val;
        req_t          kind;
        logic [7:0]    va, vb, vc, vd;
        logic [31:0]   dval;
        logic          typed;
        answer_t       want;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    tour_edge_edit_log_engine DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Predictor state of the tour, the distances and the edit log.
    logic [7:0]         tour_nbr [0:255][0:1];
    logic signed [31:0] dist_mem [0:65535];
    bit                 dist_set [0:65535];
    logic [7:0]         log_city [0:255];
    logic [7:0]         log_old  [0:255];
    logic [7:0]         log_new  [0:255];
    int unsigned        log_cnt;
    int unsigned        ring_size;

    answer_t     pending_answers[$];
    int          mismatches;
    int          results_seen;
    int          items_sent;
    int          refused_full;
    int          commits_done;
    int          idle_cycles;
    int          burst_left;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH result %0d %s: got %0h want %0h", results_seen, what, got, want);
        mismatches++;
    endtask

    function automatic void log_change(input logic [7:0] city, input logic [7:0] old_n,
                                       input logic [7:0] new_n);
        log_city[log_cnt] = city;
        log_old[log_cnt]  = old_n;
        log_new[log_cnt]  = new_n;
        log_cnt++;
        if (tour_nbr[city][0] == old_n)
            tour_nbr[city][0] = new_n;
        else
            tour_nbr[city][1] = new_n;
    endfunction

    function automatic void roll_back_log();
        int k;
        for (k = int'(log_cnt) - 1; k >= 0; k--) begin
            if (tour_nbr[log_city[k]][0] == log_new[k])
                tour_nbr[log_city[k]][0] = log_old[k];
            else
                tour_nbr[log_city[k]][1] = log_old[k];
        end
    endfunction

    // True when every distance a commit would read has been loaded.
    function automatic bit log_distances_known();
        int k;
        for (k = 0; k < int'(log_cnt); k++)
            if (!dist_set[{log_city[k], log_old[k]}] || !dist_set[{log_city[k], log_new[k]}])
                return 0;
        return 1;
    endfunction

    function automatic answer_t predict_request(input req_t kind, input logic [7:0] va,
                                                input logic [7:0] vb, input logic [7:0] vc,
                                                input logic [7:0] vd, input logic [31:0] dval);
        answer_t r;
        longint  sum;
        longint  half;
        int      i;
        r.status = ST_OK;
        r.first_nbr = '0;
        r.second_nbr = '0;
        r.delta = '0;
        case (kind)
            REQ_INIT: begin
                if (ring_size < 3 || ring_size > MaxCities) begin
                    r.status = ST_RANGE;
                end else begin
                    for (i = 1; i + 1 < int'(ring_size); i++) begin
                        tour_nbr[i][0] = 8'(i - 1);
                        tour_nbr[i][1] = 8'(i + 1);
                    end
                    tour_nbr[0][0] = 8'(ring_size - 1);
                    tour_nbr[0][1] = 8'd1;
                    tour_nbr[ring_size - 1][0] = 8'(ring_size - 2);
                    tour_nbr[ring_size - 1][1] = 8'd0;
                    log_cnt = 0;
                end
            end
            REQ_LOAD: begin
                dist_mem[{va, vb}] = dval;
                dist_set[{va, vb}] = 1;
            end
            REQ_CHANGE: begin
                if (log_cnt >= LogDepth) r.status = ST_FULL;
                else log_change(va, vb, vc);
            end
            REQ_SWAP: begin
                if (log_cnt + 4 > LogDepth) begin
                    r.status = ST_FULL;
                end else begin
                    log_change(va, vb, vc);
                    log_change(vb, va, vd);
                    log_change(vd, vc, vb);
                    log_change(vc, vd, va);
                end
            end
            REQ_QUERY: begin
                r.first_nbr = tour_nbr[va][0];
                r.second_nbr = tour_nbr[va][1];
            end
            REQ_COMMIT: begin
                roll_back_log();
                sum = 0;
                for (i = 0; i < int'(log_cnt); i++) begin
                    sum -= longint'(dist_mem[{log_city[i], log_old[i]}]);
                    sum += longint'(dist_mem[{log_city[i], log_new[i]}]);
                end
                half = sum / 2;
                if (half > 64'sd1099511627775) half = 64'sd1099511627775;
                if (half < -64'sd1099511627776) half = -64'sd1099511627776;
                r.delta = half[40:0];
                log_cnt = 0;
            end
            REQ_DISCARD: begin
                roll_back_log();
                log_cnt = 0;
            end
            default: ;
        endcase
        r.entries = log_cnt[8:0];
        return r;
    endfunction

    task automatic write_ring_size(input logic [8:0] value);
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        ring_size = value;
    endtask

    // Offers one request beat; the expectation is formed when the beat is taken.
    task automatic send_request(input req_t kind, input logic [7:0] va, input logic [7:0] vb,
                                input logic [7:0] vc, input logic [7:0] vd,
                                input logic [31:0] dval, input bit typed, input answer_t want);
        answer_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {dval, vd, vc, vb, va};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_request(kind, va, vb, vc, vd, dval);
        if (typed && r != want)
            $display("NOTE typed answer differs from predictor for request %0d", items_sent);
        pending_answers.push_back(typed ? want : r);
        if (r.status == ST_FULL) refused_full++;
        if (kind == REQ_COMMIT) commits_done++;
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
        end
    endtask

    // Result checking against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_answers.size() == 0) begin
                report_mismatch("unexpected beat", m_tdata[63:0], 64'd0);
            end else begin
                answer_t w;
                w = pending_answers.pop_front();
                if (m_tdata[1:0] != w.status) report_mismatch("status", m_tdata[1:0], w.status);
                if (m_tdata[9:2] != w.first_nbr)
                    report_mismatch("neighbor_first", m_tdata[9:2], w.first_nbr);
                if (m_tdata[17:10] != w.second_nbr)
                    report_mismatch("neighbor_second", m_tdata[17:10], w.second_nbr);
                if (m_tdata[58:18] != w.delta)
                    report_mismatch("commit_delta", m_tdata[58:18], w.delta);
                if (m_tdata[67:59] != w.entries)
                    report_mismatch("log_entries", m_tdata[67:59], w.entries);
            end
            results_seen++;
        end
    end

    // Receiver: segments of always-ready, coin-flip and mostly-stalled, plus one long hold.
    initial begin
        int  seg_len;
        int  seg_mode;
        bit  long_hold_done;
        m_tready = 1'b0;
        long_hold_done = 0;
        seg_len = 0;
        seg_mode = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!long_hold_done && results_seen >= 400) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                long_hold_done = 1;
            end else begin
                if (seg_len == 0) begin
                    seg_len = $urandom_range(1, 40);
                    seg_mode = $urandom_range(0, 2);
                end
                seg_len--;
                case (seg_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // Watchdog on cycles with no beat on any channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Watchdog expired with %0d results outstanding", pending_answers.size());
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [7:0] edit_city();
        return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
    endfunction

    task automatic random_phase(input int count, input bit fill_log);
        int   n;
        int   pick;
        logic [7:0] va, vb, vc, vd;
        answer_t none;
        none = '{ST_OK, 8'd0, 8'd0, 41'd0, 9'd0};
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            va = edit_city();
            vb = tour_nbr[va][$urandom_range(0, 1)];
            vc = edit_city();
            vd = tour_nbr[vc][$urandom_range(0, 1)];
            if ($urandom_range(0, 7) == 0) vb = 8'($urandom);
            if (pick < 20) begin
                if ($urandom_range(0, 2) == 0) begin
                    va = 8'($urandom);
                    vb = 8'($urandom);
                end
                send_request(REQ_LOAD, va, $urandom_range(0, 1) ? vb : vc, 8'($urandom),
                             8'($urandom), $urandom, 0, none);
            end else if (pick < 45) begin
                send_request(REQ_CHANGE, va, vb, vc, 8'($urandom), $urandom, 0, none);
            end else if (pick < 70) begin
                send_request(REQ_SWAP, va, vb, vc, vd, $urandom, 0, none);
            end else if (pick < 85) begin
                send_request(REQ_QUERY, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom), $urandom, 0, none);
            end else if (pick < 88 || (fill_log && pick < 99)) begin
                send_request(REQ_NONE, 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom), $urandom, 0, none);
            end else begin
                // A commit reads distances, so it is only sent when all of them are loaded.
                if (pick < 95 && log_distances_known())
                    send_request(REQ_COMMIT, va, vb, vc, vd, $urandom, 0, none);
                else
                    send_request(REQ_DISCARD, va, vb, vc, vd, $urandom, 0, none);
            end
        end
    endtask

    row_t stim_rows[$];

    task automatic add_row(input logic is_cfg, input logic [8:0] cfg_val, input req_t kind,
                           input logic [7:0] va, input logic [7:0] vb, input logic [7:0] vc,
                           input logic [7:0] vd, input logic [31:0] dval, input logic typed,
                           input answer_t want);
        row_t r;
        r = '{is_cfg, cfg_val, kind, va, vb, vc, vd, dval, typed, want};
        stim_rows.push_back(r);
    endtask

    initial begin
        answer_t none;
        int      i;
        none = '{ST_OK, 8'd0, 8'd0, 41'd0, 9'd0};
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = REQ_NONE;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        refused_full = 0;
        commits_done = 0;
        idle_cycles = 0;
        burst_left = 0;
        log_cnt = 0;
        ring_size = MaxCities;
        for (i = 0; i < 256; i++) begin
            tour_nbr[i][0] = '0;
            tour_nbr[i][1] = '0;
            log_city[i] = '0;
            log_old[i] = '0;
            log_new[i] = '0;
        end
        for (i = 0; i < 65536; i++) begin
            dist_mem[i] = '0;
            dist_set[i] = 0;
        end

        // Directed table: ring after reset, extremes, edits, undo paths and bad ring sizes.
        add_row(0, 0, REQ_INIT,  0, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 0, 0});
        add_row(0, 0, REQ_QUERY, 0, 0, 0, 0, 0, 1, '{ST_OK, 255, 1, 0, 0});
        add_row(0, 0, REQ_QUERY, 255, 0, 0, 0, 0, 1, '{ST_OK, 254, 0, 0, 0});
        add_row(0, 0, REQ_QUERY, 128, 0, 0, 0, 0, 1, '{ST_OK, 127, 129, 0, 0});
        add_row(0, 0, REQ_LOAD,  255, 255, 0, 0, 32'h8000_0000, 1, '{ST_OK, 0, 0, 0, 0});
        add_row(0, 0, REQ_LOAD,  0, 255, 0, 0, 32'h8000_0000, 1, '{ST_OK, 0, 0, 0, 0});
        add_row(0, 0, REQ_LOAD,  0, 2, 0, 0, 32'h7fff_ffff, 1, '{ST_OK, 0, 0, 0, 0});
        add_row(0, 0, REQ_LOAD,  0, 1, 0, 0, 32'd100, 1, '{ST_OK, 0, 0, 0, 0});
        add_row(0, 0, REQ_CHANGE, 0, 255, 2, 0, 0, 1, '{ST_OK, 0, 0, 0, 1});
        add_row(0, 0, REQ_QUERY, 0, 0, 0, 0, 0, 1, '{ST_OK, 2, 1, 0, 1});
        add_row(0, 0, REQ_CHANGE, 0, 1, 255, 0, 0, 0, none);
        add_row(0, 0, REQ_QUERY, 0, 0, 0, 0, 0, 0, none);
        add_row(0, 0, REQ_COMMIT, 0, 0, 0, 0, 0, 0, none);
        add_row(0, 0, REQ_QUERY, 0, 0, 0, 0, 0, 1, '{ST_OK, 255, 1, 0, 0});
        add_row(0, 0, REQ_SWAP,  5, 6, 9, 10, 0, 1, '{ST_OK, 0, 0, 0, 4});
        add_row(0, 0, REQ_QUERY, 6, 0, 0, 0, 0, 0, none);
        add_row(0, 0, REQ_DISCARD, 0, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 0, 0});
        add_row(0, 0, REQ_COMMIT, 0, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 0, 0});
        add_row(0, 0, REQ_NONE,  255, 255, 255, 255, 32'hffff_ffff, 1, '{ST_OK, 0, 0, 0, 0});
        add_row(1, 3, REQ_INIT,  0, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 0, 0});
        add_row(0, 0, REQ_QUERY, 2, 0, 0, 0, 0, 1, '{ST_OK, 1, 0, 0, 0});
        add_row(0, 0, REQ_QUERY, 3, 0, 0, 0, 0, 1, '{ST_OK, 2, 4, 0, 0});
        add_row(1, 2, REQ_INIT,  0, 0, 0, 0, 0, 1, '{ST_RANGE, 0, 0, 0, 0});
        add_row(1, 511, REQ_INIT, 0, 0, 0, 0, 0, 1, '{ST_RANGE, 0, 0, 0, 0});
        add_row(1, 256, REQ_INIT, 0, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 0, 0});

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[k]) begin
            if (stim_rows[k].is_cfg) begin
                s_tvalid <= 1'b0;
                write_ring_size(stim_rows[k].cfg_val);
            end
            send_request(stim_rows[k].kind, stim_rows[k].va, stim_rows[k].vb, stim_rows[k].vc,
                         stim_rows[k].vd, stim_rows[k].dval, stim_rows[k].typed,
                         stim_rows[k].want);
        end

        // Random phases; fill phases never commit and rarely discard, so the log runs full.
        for (i = 0; i < 6; i++) begin
            random_phase(230, (i % 2) == 1);
            s_tvalid <= 1'b0;
            case (i)
                0: write_ring_size(9'd3);
                1: write_ring_size(9'($urandom_range(4, 255)));
                2: write_ring_size(9'($urandom_range(0, 2)));
                3: write_ring_size(9'($urandom_range(257, 511)));
                default: write_ring_size(9'd256);
            endcase
            send_request(REQ_INIT, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         $urandom, 0, none);
        end

        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        $display("Sent %0d requests and checked %0d results, including %0d commits",
                 items_sent, results_seen, commits_done);
        $display("and %0d edits refused on a full log, over several ring sizes.", refused_full);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
